[rtl/tsr_pkg.sv]
package tsr_pkg;

    localparam int OP_W        = 2;
    localparam int TOUCH_W     = 10;
    localparam int STAMP_X_W   = 9;
    localparam int STAMP_Y_W   = 8;
    localparam int MASK_W      = 25;
    localparam int COLOR_W     = 16;
    localparam int BRUSH_W     = 3;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 16;

    typedef logic [OP_W-1:0]        op_t;
    typedef logic [TOUCH_W-1:0]     touch_t;
    typedef logic [STAMP_X_W-1:0]   stamp_x_t;
    typedef logic [STAMP_Y_W-1:0]   stamp_y_t;
    typedef logic [MASK_W-1:0]      mask_t;
    typedef logic [COLOR_W-1:0]     color_t;
    typedef logic [BRUSH_W-1:0]     brush_t;
    typedef logic [CFG_INDEX_W-1:0] cfg_index_t;
    typedef logic [CFG_DATA_W-1:0]  cfg_data_t;

    localparam op_t OP_PRESS    = 2'd0;
    localparam op_t OP_MOVE     = 2'd1;
    localparam op_t OP_RELEASE  = 2'd2;
    localparam op_t OP_CONTINUE = 2'd3;

    localparam cfg_index_t REG_BRUSH_WIDTH = 2'd0;
    localparam cfg_index_t REG_PEN_COLOR   = 2'd1;
    localparam cfg_index_t REG_ORIGIN_X    = 2'd2;
    localparam cfg_index_t REG_ORIGIN_Y    = 2'd3;

    localparam brush_t BRUSH_RESET = 3'd2;
    localparam color_t COLOR_RESET = 16'd61958;

    // 5x5 disc of radius r around the center, bit (dy+2)*5+(dx+2)
    function automatic mask_t disc_mask(input logic [1:0] r);
        mask_t m;
        int    rr;
        m  = '0;
        rr = int'(r) * int'(r);
        for (int dy = -2; dy <= 2; dy++)
        begin
            for (int dx = -2; dx <= 2; dx++)
            begin
                if (dx * dx + dy * dy <= rr)
                begin
                    m[(dy + 2) * 5 + (dx + 2)] = 1'b1;
                end
            end
        end
        return m;
    endfunction

endpackage

[rtl/tsr_touch_if.sv]
interface tsr_touch_if;
    logic            valid;
    logic            ready;
    tsr_pkg::op_t    operation;
    tsr_pkg::touch_t touch_x;
    tsr_pkg::touch_t touch_y;

    modport source (output valid, output operation, output touch_x, output touch_y,
                    input ready);
    modport sink   (input valid, input operation, input touch_x, input touch_y,
                    output ready);
endinterface

[rtl/tsr_stamp_if.sv]
interface tsr_stamp_if;
    logic              valid;
    logic              ready;
    tsr_pkg::stamp_x_t stamp_x;
    tsr_pkg::stamp_y_t stamp_y;
    tsr_pkg::mask_t    cover_mask;
    tsr_pkg::color_t   stamp_color;
    logic              batch_last;
    logic              more_pending;

    modport source (output valid, output stamp_x, output stamp_y, output cover_mask,
                    output stamp_color, output batch_last, output more_pending,
                    input ready);
    modport sink   (input valid, input stamp_x, input stamp_y, input cover_mask,
                    input stamp_color, input batch_last, input more_pending,
                    output ready);
endinterface

[rtl/tsr_bresenham_step.sv]
module tsr_bresenham_step #(
    parameter int XW = 9,
    parameter int YW = 8,
    parameter int EW = 11
) (
    input  logic [XW-1:0]        cur_x,
    input  logic [YW-1:0]        cur_y,
    input  logic signed [EW-1:0] cur_err,
    input  logic [XW-1:0]        span_x,
    input  logic [YW-1:0]        span_y,
    input  logic [1:0]           dir,
    output logic [XW-1:0]        new_x,
    output logic [YW-1:0]        new_y,
    output logic signed [EW-1:0] new_err
);

    logic signed [EW:0]   e2;
    logic signed [EW:0]   sx_wide;
    logic signed [EW:0]   sy_wide;
    logic signed [EW-1:0] sx_ext;
    logic signed [EW-1:0] sy_ext;
    logic                 mv_x;
    logic                 mv_y;

    assign e2      = {cur_err, 1'b0};
    assign sx_wide = $signed({{(EW + 1 - XW){1'b0}}, span_x});
    assign sy_wide = $signed({{(EW + 1 - YW){1'b0}}, span_y});
    assign sx_ext  = $signed({{(EW - XW){1'b0}}, span_x});
    assign sy_ext  = $signed({{(EW - YW){1'b0}}, span_y});

    assign mv_x = e2 > -sy_wide;
    assign mv_y = e2 < sx_wide;

    always_comb
    begin
        new_err = cur_err;
        if (mv_x)
        begin
            new_err = new_err - sy_ext;
        end
        if (mv_y)
        begin
            new_err = new_err + sx_ext;
        end
    end

    always_comb
    begin
        new_x = cur_x;
        new_y = cur_y;
        if (mv_x)
        begin
            new_x = dir[0] ? cur_x - XW'(1) : cur_x + XW'(1);
        end
        if (mv_y)
        begin
            new_y = dir[1] ? cur_y - YW'(1) : cur_y + YW'(1);
        end
    end

endmodule

[rtl/touch_stroke_rasterizer.sv]
// Flow: a touch request is latched in S_IDLE, then S_DECODE, S_MEASURE and S_WALK
// follow; S_WALK registers one stamp per cycle from a single shared Bresenham step
// unit while the stamp sink is ready, up to MAX_BATCH stamps per item. Release and
// ignored points return to S_IDLE from S_DECODE. No new touch request is taken
// until the walk ends. Reset (rst_n low, async): registers return to their defaults
// (brush 2, color 61958, origin 0), no remembered point and no pending segment.
module touch_stroke_rasterizer #(
    parameter int CANVAS_W  = 300,
    parameter int CANVAS_H  = 200,
    parameter int MAX_BATCH = 64
) (
    input  logic                clk,
    input  logic                rst_n,
    tsr_touch_if.sink           touch,
    tsr_stamp_if.source         stamp,
    input  logic                cfg_we,
    input  tsr_pkg::cfg_index_t cfg_index,
    input  tsr_pkg::cfg_data_t  cfg_data
);

    localparam int XW = $clog2(CANVAS_W);
    localparam int YW = $clog2(CANVAS_H);
    localparam int DW = (XW > YW) ? XW : YW;
    localparam int EW = DW + 2;
    localparam int BW = $clog2(MAX_BATCH + 1);
    localparam int SW = tsr_pkg::TOUCH_W + 1;
    localparam int CW = DW + 7;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DECODE,
        S_MEASURE,
        S_WALK
    } state_t;

    state_t                state_reg,      state_next;
    tsr_pkg::brush_t       brush_reg,      brush_next;
    tsr_pkg::color_t       color_reg,      color_next;
    tsr_pkg::touch_t       org_x_reg,      org_x_next;
    tsr_pkg::touch_t       org_y_reg,      org_y_next;
    tsr_pkg::op_t          op_reg,         op_next;
    tsr_pkg::touch_t       tx_reg,         tx_next;
    tsr_pkg::touch_t       ty_reg,         ty_next;
    logic                  prev_valid_reg, prev_valid_next;
    logic [XW-1:0]         prev_x_reg,     prev_x_next;
    logic [YW-1:0]         prev_y_reg,     prev_y_next;
    logic [XW-1:0]         walk_x_reg,     walk_x_next;
    logic [YW-1:0]         walk_y_reg,     walk_y_next;
    logic [XW-1:0]         goal_x_reg,     goal_x_next;
    logic [YW-1:0]         goal_y_reg,     goal_y_next;
    logic signed [EW-1:0]  err_reg,        err_next;
    logic [XW-1:0]         span_x_reg,     span_x_next;
    logic [YW-1:0]         span_y_reg,     span_y_next;
    logic [1:0]            dir_reg,        dir_next;
    logic                  pending_reg,    pending_next;
    logic                  more_reg,       more_next;
    logic [BW-1:0]         cnt_reg,        cnt_next;
    logic                  out_valid_reg,  out_valid_next;
    tsr_pkg::stamp_x_t     out_x_reg,      out_x_next;
    tsr_pkg::stamp_y_t     out_y_reg,      out_y_next;
    tsr_pkg::mask_t        out_mask_reg,   out_mask_next;
    tsr_pkg::color_t       out_color_reg,  out_color_next;
    logic                  out_last_reg,   out_last_next;
    logic                  out_more_reg,   out_more_next;

    logic signed [SW-1:0]  cx;
    logic signed [SW-1:0]  cy;
    logic                  on_canvas;
    logic [XW-1:0]         cx_c;
    logic [YW-1:0]         cy_c;
    logic [XW-1:0]         ax;
    logic [YW-1:0]         ay;
    logic [XW-1:0]         gdx;
    logic [YW-1:0]         gdy;
    logic [DW-1:0]         cheb;
    logic                  at_goal;
    logic                  batch_end;
    logic                  slot_free;
    logic [4:0]            col_ok;
    logic [4:0]            row_ok;
    tsr_pkg::mask_t        clip;
    tsr_pkg::mask_t        mask;
    logic [XW-1:0]         step_x;
    logic [YW-1:0]         step_y;
    logic signed [EW-1:0]  step_err;

    tsr_bresenham_step #(
        .XW (XW),
        .YW (YW),
        .EW (EW)
    ) u_step (
        .cur_x   (walk_x_reg),
        .cur_y   (walk_y_reg),
        .cur_err (err_reg),
        .span_x  (span_x_reg),
        .span_y  (span_y_reg),
        .dir     (dir_reg),
        .new_x   (step_x),
        .new_y   (step_y),
        .new_err (step_err)
    );

    // canvas-relative point of the latched request
    assign cx = $signed({1'b0, tx_reg}) - $signed({1'b0, org_x_reg});
    assign cy = $signed({1'b0, ty_reg}) - $signed({1'b0, org_y_reg});
    assign on_canvas = !cx[SW-1] && !cy[SW-1]
                    && (cx[SW-2:0] < (SW - 1)'(CANVAS_W))
                    && (cy[SW-2:0] < (SW - 1)'(CANVAS_H));
    assign cx_c = cx[XW-1:0];
    assign cy_c = cy[YW-1:0];
    assign ax   = (cx_c > prev_x_reg) ? cx_c - prev_x_reg : prev_x_reg - cx_c;
    assign ay   = (cy_c > prev_y_reg) ? cy_c - prev_y_reg : prev_y_reg - cy_c;

    // Bresenham always advances the major axis, so steps left = Chebyshev distance
    assign gdx  = (goal_x_reg > walk_x_reg) ? goal_x_reg - walk_x_reg
                                            : walk_x_reg - goal_x_reg;
    assign gdy  = (goal_y_reg > walk_y_reg) ? goal_y_reg - walk_y_reg
                                            : walk_y_reg - goal_y_reg;
    assign cheb = (DW'(gdx) > DW'(gdy)) ? DW'(gdx) : DW'(gdy);

    assign at_goal   = (walk_x_reg == goal_x_reg) && (walk_y_reg == goal_y_reg);
    assign batch_end = (cnt_reg == BW'(MAX_BATCH - 1));
    assign slot_free = !out_valid_reg || stamp.ready;

    // canvas clipping of the 5x5 window
    assign col_ok[0] = walk_x_reg >= XW'(2);
    assign col_ok[1] = walk_x_reg >= XW'(1);
    assign col_ok[2] = 1'b1;
    assign col_ok[3] = walk_x_reg <= XW'(CANVAS_W - 2);
    assign col_ok[4] = walk_x_reg <= XW'(CANVAS_W - 3);
    assign row_ok[0] = walk_y_reg >= YW'(2);
    assign row_ok[1] = walk_y_reg >= YW'(1);
    assign row_ok[2] = 1'b1;
    assign row_ok[3] = walk_y_reg <= YW'(CANVAS_H - 2);
    assign row_ok[4] = walk_y_reg <= YW'(CANVAS_H - 3);

    always_comb
    begin
        for (int i = 0; i < 5; i++)
        begin
            for (int j = 0; j < 5; j++)
            begin
                clip[i * 5 + j] = row_ok[i] & col_ok[j];
            end
        end
    end

    assign mask = tsr_pkg::disc_mask(brush_reg[2:1]) & clip;

    always_comb
    begin
        state_next      = state_reg;
        brush_next      = brush_reg;
        color_next      = color_reg;
        org_x_next      = org_x_reg;
        org_y_next      = org_y_reg;
        op_next         = op_reg;
        tx_next         = tx_reg;
        ty_next         = ty_reg;
        prev_valid_next = prev_valid_reg;
        prev_x_next     = prev_x_reg;
        prev_y_next     = prev_y_reg;
        walk_x_next     = walk_x_reg;
        walk_y_next     = walk_y_reg;
        goal_x_next     = goal_x_reg;
        goal_y_next     = goal_y_reg;
        err_next        = err_reg;
        span_x_next     = span_x_reg;
        span_y_next     = span_y_reg;
        dir_next        = dir_reg;
        pending_next    = pending_reg;
        more_next       = more_reg;
        cnt_next        = cnt_reg;
        out_valid_next  = out_valid_reg && !stamp.ready;
        out_x_next      = out_x_reg;
        out_y_next      = out_y_reg;
        out_mask_next   = out_mask_reg;
        out_color_next  = out_color_reg;
        out_last_next   = out_last_reg;
        out_more_next   = out_more_reg;

        if (cfg_we)
        begin
            case (cfg_index)
                tsr_pkg::REG_BRUSH_WIDTH: brush_next = cfg_data[tsr_pkg::BRUSH_W-1:0];
                tsr_pkg::REG_PEN_COLOR:   color_next = cfg_data;
                tsr_pkg::REG_ORIGIN_X:    org_x_next = cfg_data[tsr_pkg::TOUCH_W-1:0];
                tsr_pkg::REG_ORIGIN_Y:    org_y_next = cfg_data[tsr_pkg::TOUCH_W-1:0];
                default: ;
            endcase
        end

        case (state_reg)
            S_IDLE:
            begin
                if (touch.valid)
                begin
                    op_next    = touch.operation;
                    tx_next    = touch.touch_x;
                    ty_next    = touch.touch_y;
                    state_next = S_DECODE;
                end
            end

            S_DECODE:
            begin
                cnt_next   = '0;
                state_next = S_IDLE;
                case (op_reg)
                    tsr_pkg::OP_RELEASE:
                    begin
                        prev_valid_next = 1'b0;
                    end
                    tsr_pkg::OP_CONTINUE:
                    begin
                        if (pending_reg)
                        begin
                            state_next = S_MEASURE;
                        end
                    end
                    default:
                    begin
                        pending_next = 1'b0;
                        if (!on_canvas)
                        begin
                            if (op_reg == tsr_pkg::OP_PRESS)
                            begin
                                prev_valid_next = 1'b0;
                            end
                        end
                        else
                        begin
                            goal_x_next = cx_c;
                            goal_y_next = cy_c;
                            if (prev_valid_reg)
                            begin
                                walk_x_next = prev_x_reg;
                                walk_y_next = prev_y_reg;
                                span_x_next = ax;
                                span_y_next = ay;
                                dir_next    = {!(prev_y_reg < cy_c), !(prev_x_reg < cx_c)};
                                err_next    = $signed({{(EW - XW){1'b0}}, ax})
                                            - $signed({{(EW - YW){1'b0}}, ay});
                            end
                            else
                            begin
                                // single dot: a zero-length walk
                                walk_x_next = cx_c;
                                walk_y_next = cy_c;
                            end
                            pending_next    = 1'b1;
                            prev_x_next     = cx_c;
                            prev_y_next     = cy_c;
                            prev_valid_next = 1'b1;
                            state_next      = S_MEASURE;
                        end
                    end
                endcase
            end

            S_MEASURE:
            begin
                more_next  = CW'(cheb) >= CW'(MAX_BATCH);
                state_next = S_WALK;
            end

            S_WALK:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    out_x_next     = tsr_pkg::stamp_x_t'(walk_x_reg);
                    out_y_next     = tsr_pkg::stamp_y_t'(walk_y_reg);
                    out_mask_next  = mask;
                    out_color_next = color_reg;
                    out_last_next  = at_goal || batch_end;
                    out_more_next  = more_reg;
                    if (at_goal)
                    begin
                        pending_next = 1'b0;
                        state_next   = S_IDLE;
                    end
                    else
                    begin
                        walk_x_next = step_x;
                        walk_y_next = step_y;
                        err_next    = step_err;
                        if (batch_end)
                        begin
                            state_next = S_IDLE;
                        end
                        else
                        begin
                            cnt_next = cnt_reg + BW'(1);
                        end
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            brush_reg      <= tsr_pkg::BRUSH_RESET;
            color_reg      <= tsr_pkg::COLOR_RESET;
            org_x_reg      <= '0;
            org_y_reg      <= '0;
            op_reg         <= tsr_pkg::OP_PRESS;
            tx_reg         <= '0;
            ty_reg         <= '0;
            prev_valid_reg <= 1'b0;
            prev_x_reg     <= '0;
            prev_y_reg     <= '0;
            walk_x_reg     <= '0;
            walk_y_reg     <= '0;
            goal_x_reg     <= '0;
            goal_y_reg     <= '0;
            err_reg        <= '0;
            span_x_reg     <= '0;
            span_y_reg     <= '0;
            dir_reg        <= '0;
            pending_reg    <= 1'b0;
            more_reg       <= 1'b0;
            cnt_reg        <= '0;
            out_valid_reg  <= 1'b0;
            out_x_reg      <= '0;
            out_y_reg      <= '0;
            out_mask_reg   <= '0;
            out_color_reg  <= '0;
            out_last_reg   <= 1'b0;
            out_more_reg   <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            brush_reg      <= brush_next;
            color_reg      <= color_next;
            org_x_reg      <= org_x_next;
            org_y_reg      <= org_y_next;
            op_reg         <= op_next;
            tx_reg         <= tx_next;
            ty_reg         <= ty_next;
            prev_valid_reg <= prev_valid_next;
            prev_x_reg     <= prev_x_next;
            prev_y_reg     <= prev_y_next;
            walk_x_reg     <= walk_x_next;
            walk_y_reg     <= walk_y_next;
            goal_x_reg     <= goal_x_next;
            goal_y_reg     <= goal_y_next;
            err_reg        <= err_next;
            span_x_reg     <= span_x_next;
            span_y_reg     <= span_y_next;
            dir_reg        <= dir_next;
            pending_reg    <= pending_next;
            more_reg       <= more_next;
            cnt_reg        <= cnt_next;
            out_valid_reg  <= out_valid_next;
            out_x_reg      <= out_x_next;
            out_y_reg      <= out_y_next;
            out_mask_reg   <= out_mask_next;
            out_color_reg  <= out_color_next;
            out_last_reg   <= out_last_next;
            out_more_reg   <= out_more_next;
        end
    end

    assign touch.ready        = (state_reg == S_IDLE);
    assign stamp.valid        = out_valid_reg;
    assign stamp.stamp_x      = out_x_reg;
    assign stamp.stamp_y      = out_y_reg;
    assign stamp.cover_mask   = out_mask_reg;
    assign stamp.stamp_color  = out_color_reg;
    assign stamp.batch_last   = out_last_reg;
    assign stamp.more_pending = out_more_reg;

`ifndef SYNTHESIS
    // batch counter never reaches the batch size
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg < BW'(MAX_BATCH))
        else $error("stamp batch counter overran");

    // a stamp that is not the last of its batch is always followed by the walk
    a_more_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (stamp.valid && stamp.ready && !stamp.batch_last) |-> (state_reg == S_WALK))
        else $error("non-final stamp taken with no walk in progress");

    // the walk never leaves the canvas and always has a pending segment
    a_walk_on_canvas: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WALK) |->
            (walk_x_reg < XW'(CANVAS_W)) && (walk_y_reg < YW'(CANVAS_H)) && pending_reg)
        else $error("walk point off canvas or walk without pending segment");
`endif

endmodule

[tb/touch_stroke_rasterizer_tb.sv]
module touch_stroke_rasterizer_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import tsr_pkg::*;

    localparam int CANVAS_W  = 300;
    localparam int CANVAS_H  = 200;
    localparam int MAX_BATCH = 64;
    localparam int PHASES    = 8;
    localparam int PHASE_REQ = 48;

    typedef struct packed {
        stamp_x_t x;
        stamp_y_t y;
        mask_t    mask;
        color_t   color;
        logic     last;
        logic     more;
    } stamp_rec_t;

    // Stroke predictor plus the queue of stamps still owed by the block
    class stroke_scoreboard;
        int         brush;
        int         color;
        int         org_x;
        int         org_y;
        bit         prev_valid;
        int         prev_x;
        int         prev_y;
        int         walk_x;
        int         walk_y;
        int         goal_x;
        int         goal_y;
        int         step_err;
        int         span_x;
        int         span_y;
        bit         step_left;
        bit         step_up;
        bit         seg_pending;
        stamp_rec_t batch[$];
        stamp_rec_t expected_stamps[$];
        int         errors;
        int         stamps_checked;
        int         split_batches;
        int         reg_writes;
        int         op_count[4];

        function void clear();
            brush          = int'(BRUSH_RESET);
            color          = int'(COLOR_RESET);
            org_x          = 0;
            org_y          = 0;
            prev_valid     = 1'b0;
            prev_x         = 0;
            prev_y         = 0;
            walk_x         = 0;
            walk_y         = 0;
            goal_x         = 0;
            goal_y         = 0;
            step_err       = 0;
            span_x         = 0;
            span_y         = 0;
            step_left      = 1'b0;
            step_up        = 1'b0;
            seg_pending    = 1'b0;
            errors         = 0;
            stamps_checked = 0;
            split_batches  = 0;
            reg_writes     = 0;
            foreach (op_count[i])
                op_count[i] = 0;
        endfunction

        function void write_reg(cfg_index_t idx, cfg_data_t data);
            reg_writes++;
            case (idx)
                REG_BRUSH_WIDTH: brush = int'(data[BRUSH_W-1:0]);
                REG_PEN_COLOR:   color = int'(data);
                REG_ORIGIN_X:    org_x = int'(data[TOUCH_W-1:0]);
                REG_ORIGIN_Y:    org_y = int'(data[TOUCH_W-1:0]);
                default:         ;
            endcase
        endfunction

        // disc of radius brush/2, cut to the 5x5 window and to the canvas
        function mask_t disc_cover(int cx, int cy);
            mask_t m;
            int    r2;
            m  = '0;
            r2 = (brush / 2) * (brush / 2);
            for (int dy = -2; dy <= 2; dy++)
            begin
                for (int dx = -2; dx <= 2; dx++)
                begin
                    if (dx * dx + dy * dy <= r2 && cx + dx >= 0 && cx + dx < CANVAS_W &&
                        cy + dy >= 0 && cy + dy < CANVAS_H)
                    begin
                        m[(dy + 2) * 5 + (dx + 2)] = 1'b1;
                    end
                end
            end
            return m;
        endfunction

        function void add_stamp(int x, int y);
            stamp_rec_t s;
            s.x     = stamp_x_t'(x);
            s.y     = stamp_y_t'(y);
            s.mask  = disc_cover(x, y);
            s.color = color_t'(color);
            s.last  = 1'b0;
            s.more  = 1'b0;
            batch.push_back(s);
        endfunction

        function void walk_line();
            int e2;
            while (seg_pending)
            begin
                add_stamp(walk_x, walk_y);
                if (walk_x == goal_x && walk_y == goal_y)
                begin
                    seg_pending = 1'b0;
                    break;
                end
                e2 = 2 * step_err;
                if (e2 > -span_y)
                begin
                    step_err -= span_y;
                    walk_x   += step_left ? -1 : 1;
                end
                if (e2 < span_x)
                begin
                    step_err += span_x;
                    walk_y   += step_up ? -1 : 1;
                end
                if (batch.size() >= MAX_BATCH)
                    break;
            end
        endfunction

        function int note_touch(op_t op, touch_t tx, touch_t ty);
            int cx;
            int cy;
            int n;
            cx = int'(tx) - org_x;
            cy = int'(ty) - org_y;
            batch.delete();
            op_count[op]++;
            if (op == OP_RELEASE)
            begin
                prev_valid = 1'b0;
            end
            else if (op == OP_CONTINUE)
            begin
                walk_line();
            end
            else
            begin
                seg_pending = 1'b0;
                if (cx < 0 || cx >= CANVAS_W || cy < 0 || cy >= CANVAS_H)
                begin
                    if (op == OP_PRESS)
                        prev_valid = 1'b0;
                end
                else
                begin
                    if (!prev_valid)
                    begin
                        add_stamp(cx, cy);
                    end
                    else
                    begin
                        walk_x      = prev_x;
                        walk_y      = prev_y;
                        goal_x      = cx;
                        goal_y      = cy;
                        span_x      = (cx > prev_x) ? cx - prev_x : prev_x - cx;
                        span_y      = (cy > prev_y) ? cy - prev_y : prev_y - cy;
                        step_left   = !(prev_x < cx);
                        step_up     = !(prev_y < cy);
                        step_err    = span_x - span_y;
                        seg_pending = 1'b1;
                        walk_line();
                    end
                    prev_x     = cx;
                    prev_y     = cy;
                    prev_valid = 1'b1;
                end
            end
            n = batch.size();
            for (int k = 0; k < n; k++)
            begin
                batch[k].more = seg_pending;
                batch[k].last = (k == n - 1);
                expected_stamps.push_back(batch[k]);
            end
            if (n > 0 && seg_pending)
                split_batches++;
            return n;
        endfunction

        function void compare(string field, longint unsigned want, longint unsigned got);
            if (want != got)
            begin
                errors++;
                $display("%0t: %s mismatch, expected %0h, got %0h", $time, field, want, got);
            end
        endfunction

        function void check_stamp(stamp_rec_t got);
            stamp_rec_t want;
            if (expected_stamps.size() == 0)
            begin
                errors++;
                $display("%0t: stamp x=%0d y=%0d with none expected", $time, got.x, got.y);
                return;
            end
            want = expected_stamps.pop_front();
            stamps_checked++;
            compare("stamp_x", want.x, got.x);
            compare("stamp_y", want.y, got.y);
            compare("cover_mask", want.mask, got.mask);
            compare("stamp_color", want.color, got.color);
            compare("batch_last", want.last, got.last);
            compare("more_pending", want.more, got.more);
        endfunction
    endclass

    logic       clk;
    logic       rst_n;
    logic       cfg_we;
    cfg_index_t cfg_index;
    cfg_data_t  cfg_data;

    tsr_touch_if touch_bus ();
    tsr_stamp_if stamp_bus ();

    stroke_scoreboard sb;

    int send_pct;
    int recv_pct;
    int hold_req;
    int counted_items;

    touch_stroke_rasterizer #(
        .CANVAS_W  (CANVAS_W),
        .CANVAS_H  (CANVAS_H),
        .MAX_BATCH (MAX_BATCH)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .touch     (touch_bus),
        .stamp     (stamp_bus),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #20_000_000;
        $display("timeout, %0d stamps still expected", sb.expected_stamps.size());
        $display("FAIL");
        $finish;
    end

    // stamp sink: random stalls, plus long hold-offs on request
    initial
    begin
        int hold_left;
        hold_left       = 0;
        stamp_bus.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req > 0)
            begin
                hold_left = hold_req;
                hold_req  = 0;
            end
            if (hold_left > 0)
            begin
                stamp_bus.ready = 1'b0;
                hold_left--;
            end
            else
            begin
                stamp_bus.ready = ($urandom_range(0, 99) >= recv_pct);
            end
        end
    end

    always @(posedge clk)
    begin
        stamp_rec_t got;
        if (rst_n && stamp_bus.valid && stamp_bus.ready)
        begin
            got.x     = stamp_bus.stamp_x;
            got.y     = stamp_bus.stamp_y;
            got.mask  = stamp_bus.cover_mask;
            got.color = stamp_bus.stamp_color;
            got.last  = stamp_bus.batch_last;
            got.more  = stamp_bus.more_pending;
            sb.check_stamp(got);
        end
    end

    // leaves valid high after the request is taken; the next call replaces or lowers it, a drain lowers it
    task automatic send_touch(op_t op, int x, int y);
        int n;
        while ($urandom_range(0, 99) < send_pct)
        begin
            @(negedge clk);
            touch_bus.valid = 1'b0;
        end
        @(negedge clk);
        touch_bus.valid     = 1'b1;
        touch_bus.operation = op;
        touch_bus.touch_x   = touch_t'(x);
        touch_bus.touch_y   = touch_t'(y);
        do
            @(posedge clk);
        while (!touch_bus.ready);
        n = sb.note_touch(op, touch_t'(x), touch_t'(y));
        if (n > 0 || op == OP_PRESS || op == OP_RELEASE)
            counted_items++;
    endtask

    task automatic wait_drained();
        @(negedge clk);
        touch_bus.valid = 1'b0;
        while (sb.expected_stamps.size() != 0)
            @(posedge clk);
        // release and off-canvas requests still occupy the block briefly
        repeat (8) @(posedge clk);
    endtask

    task automatic program_reg(cfg_index_t idx, int value);
        @(negedge clk);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = cfg_data_t'(value);
        @(posedge clk);
        sb.write_reg(idx, cfg_data);
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    task automatic set_config(int brush, int color, int ox, int oy);
        program_reg(REG_BRUSH_WIDTH, brush);
        program_reg(REG_PEN_COLOR, color);
        program_reg(REG_ORIGIN_X, ox);
        program_reg(REG_ORIGIN_Y, oy);
    endtask

    function automatic int pick_coord(int cur, int lim, bit far);
        int v;
        if (far)
            return $urandom_range(0, lim);
        v = cur + $urandom_range(0, 24) - 12;
        if (v < 0)
            v = 0;
        if (v > lim)
            v = lim;
        return v;
    endfunction

    task automatic run_strokes(int target);
        int start;
        int xlim;
        int ylim;
        int cx;
        int cy;
        int moves;
        int r;
        op_t op;
        start = counted_items;
        xlim  = (1023 - sb.org_x < CANVAS_W - 1) ? 1023 - sb.org_x : CANVAS_W - 1;
        ylim  = (1023 - sb.org_y < CANVAS_H - 1) ? 1023 - sb.org_y : CANVAS_H - 1;
        while (counted_items - start < target)
        begin
            if ($urandom_range(0, 99) < 75)
            begin
                cx = $urandom_range(0, xlim);
                cy = $urandom_range(0, ylim);
                send_touch(OP_PRESS, sb.org_x + cx, sb.org_y + cy);
                moves = $urandom_range(1, 6);
                repeat (moves)
                begin
                    op = ($urandom_range(0, 99) < 15) ? OP_PRESS : OP_MOVE;
                    cx = pick_coord(cx, xlim, $urandom_range(0, 99) < 20);
                    cy = pick_coord(cy, ylim, $urandom_range(0, 99) < 20);
                    send_touch(op, sb.org_x + cx, sb.org_y + cy);
                    while (sb.seg_pending)
                    begin
                        r = $urandom_range(0, 99);
                        if (r < 85)
                            send_touch(OP_CONTINUE, $urandom_range(0, 1023),
                                       $urandom_range(0, 1023));
                        else if (r < 92)
                            send_touch(OP_RELEASE, 0, 0);
                        else
                            break;
                    end
                end
                if ($urandom_range(0, 99) < 85)
                    send_touch(OP_RELEASE, $urandom_range(0, 1023), $urandom_range(0, 1023));
            end
            else
            begin
                send_touch(op_t'($urandom_range(0, 3)), $urandom_range(0, 1023),
                           $urandom_range(0, 1023));
            end
        end
    endtask

    initial
    begin
        int brush_tab [PHASES] = '{2, 0, 5, 3, 4, 6, 7, 1};
        int color_tab [PHASES] = '{-1, 65535, -1, 0, -1, -1, -1, -1};
        int ox_tab    [PHASES] = '{0, 100, 723, 0, -1, -1, -1, 724};
        int oy_tab    [PHASES] = '{0, 50, 823, 824, -1, -1, -1, 0};
        int send_tab  [PHASES] = '{0, 61, 0, 35, 0, 61, 0, 35};
        int recv_tab  [PHASES] = '{0, 0, 61, 35, 0, 0, 61, 35};
        int ox;
        int oy;
        int color;

        sb = new();
        sb.clear();
        rst_n               = 1'b0;
        cfg_we              = 1'b0;
        cfg_index           = REG_BRUSH_WIDTH;
        cfg_data            = '0;
        touch_bus.valid     = 1'b0;
        touch_bus.operation = OP_PRESS;
        touch_bus.touch_x   = '0;
        touch_bus.touch_y   = '0;
        send_pct            = 0;
        recv_pct            = 0;
        hold_req            = 0;
        counted_items       = 0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed part, reset configuration
        send_touch(OP_CONTINUE, 0, 0);        // continue with nothing pending
        send_touch(OP_MOVE, 0, 0);            // first point: corner dot
        send_touch(OP_PRESS, 299, 199);       // press with a remembered point, long line
        send_touch(OP_CONTINUE, 0, 0);
        send_touch(OP_RELEASE, 0, 0);         // segment survives the release
        send_touch(OP_CONTINUE, 0, 0);
        send_touch(OP_CONTINUE, 0, 0);
        send_touch(OP_CONTINUE, 0, 0);
        send_touch(OP_CONTINUE, 0, 0);
        send_touch(OP_PRESS, 300, 5);         // off canvas press forgets the point
        send_touch(OP_PRESS, 1023, 1023);
        send_touch(OP_PRESS, 10, 10);
        send_touch(OP_MOVE, 10, 10);          // zero-length line
        send_touch(OP_MOVE, 500, 10);         // off canvas move keeps the point
        send_touch(OP_MOVE, 20, 15);
        send_touch(OP_MOVE, 0, 199);
        send_touch(OP_PRESS, 5, 5);           // drops the unfinished walk
        send_touch(OP_MOVE, 1023, 0);         // off canvas move still drops the walk
        send_touch(OP_CONTINUE, 0, 0);
        wait_drained();

        // wide brush, origin at the far corner: canvas is a single screen pixel
        set_config(7, 0, 1023, 1023);
        send_touch(OP_PRESS, 1023, 1023);
        send_touch(OP_MOVE, 1022, 1023);
        send_touch(OP_RELEASE, 1023, 1023);
        send_touch(OP_PRESS, 1023, 1023);
        wait_drained();

        for (int p = 0; p < PHASES; p++)
        begin
            ox    = (ox_tab[p] < 0) ? $urandom_range(0, 724) : ox_tab[p];
            oy    = (oy_tab[p] < 0) ? $urandom_range(0, 824) : oy_tab[p];
            color = (color_tab[p] < 0) ? $urandom_range(0, 65535) : color_tab[p];
            set_config(brush_tab[p], color, ox, oy);
            send_pct = send_tab[p];
            recv_pct = recv_tab[p];
            if (p == 4)
            begin
                // sink held off while a long line keeps the block busy
                hold_req = 400;
                send_touch(OP_PRESS, ox, oy);
                send_touch(OP_MOVE, ox + CANVAS_W - 1, oy + CANVAS_H - 1);
                while (sb.seg_pending)
                    send_touch(OP_CONTINUE, 0, 0);
                send_touch(OP_MOVE, ox, oy + CANVAS_H - 1);
            end
            if (p == 2)
            begin
                run_strokes(PHASE_REQ / 2);
                wait_drained();
                run_strokes(PHASE_REQ / 2);
            end
            else
            begin
                run_strokes(PHASE_REQ);
            end
            wait_drained();
        end

        repeat (20) @(posedge clk);
        if (sb.expected_stamps.size() != 0)
        begin
            sb.errors += sb.expected_stamps.size();
            $display("%0t: %0d expected stamps never arrived", $time,
                     sb.expected_stamps.size());
        end

        $display("Requests: %0d press, %0d move, %0d release, %0d continue; %0d stamps checked",
                 sb.op_count[OP_PRESS], sb.op_count[OP_MOVE], sb.op_count[OP_RELEASE],
                 sb.op_count[OP_CONTINUE], sb.stamps_checked);
        $display("%0d batches cut at the batch limit, %0d register writes over brush 0..7",
                 sb.split_batches, sb.reg_writes);
        if (sb.errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
